### rtl/ste_pkg.sv
// ----------------------------------------------------------------------------
// ste_pkg
// Shared types and constants for the segment/triangle intersection pipeline.
// ----------------------------------------------------------------------------
package ste_pkg;

	// Per-request status carried down the pipeline next to the data
	typedef struct packed {
		logic       miss;      // both segment ends strictly on one side
		logic       den_zero;  // both segment ends at the same plane distance
		logic [2:0] neg;       // per-axis sign of the crossing numerator
	} ste_flags_t;

	// Cyclic axis successors and predecessors for cross products and triangle edges
	localparam int AX_NEXT [3] = '{1, 2, 0};
	localparam int AX_PREV [3] = '{2, 0, 1};

endpackage

### rtl/ste_plane.sv
// ----------------------------------------------------------------------------
// ste_plane
// Plane distances, crossing denominator and per-axis numerator magnitudes.
// ----------------------------------------------------------------------------
module ste_plane #(
	parameter int W  = 16,
	parameter int DW = 2*W+4,
	parameter int NW = 3*W+6
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic [3*W-1:0]         s_i,
	input  logic [3*W-1:0]         e_i,
	input  logic [3*W-1:0]         a_i,
	input  logic [3*W-1:0]         b_i,
	input  logic [3*W-1:0]         c_i,
	input  logic [3*W-1:0]         n_i,
	output logic                   out_valid,
	output ste_pkg::ste_flags_t    flags_o,
	output logic [2:0][NW-1:0]     mag_o,
	output logic [DW-1:0]          den_o,
	output logic [12*W-1:0]        side_o
);
	import ste_pkg::*;

	localparam int PW = 2*W+1;
	localparam int SW = 2*W+3;
	localparam int MW = 3*W+5;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	logic [12*W-1:0] pts_s1, pts_s2, pts_s3, pts_s4, pts_s5, pts_s6, pts_s7;
	logic [3*W-1:0]  n_s1;
	logic signed [W:0] sd_s1 [3];
	logic signed [W:0] ed_s1 [3];
	logic signed [W:0] es_s1 [3];
	logic signed [W:0] es_s2 [3];
	logic signed [W:0] es_s3 [3];
	logic signed [W:0] es_s4 [3];
	logic signed [PW-1:0] p0_s2 [3];
	logic signed [PW-1:0] p1_s2 [3];
	logic signed [SW-1:0] d0_s3, d1_s3;
	logic [DW-1:0]        den_s4, den_s5, den_s6, den_s7;
	logic signed [DW-1:0] d0n_s4;
	logic signed [MW-1:0] m1_s5 [3];
	logic signed [MW-1:0] m2_s5 [3];
	logic signed [NW-1:0] num_s6 [3];
	logic [NW-1:0]        mag_s7 [3];
	ste_flags_t flg_s4, flg_s5, flg_s6, flg_s7;

	logic signed [DW-1:0] diff_c, d0w_c, d0n_c;
	logic [DW-1:0]        den_c;
	logic                 miss_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// Sign-normalize so that den >= 0 and, when not a miss, 0 <= d0 <= den
	always_comb begin
		d0w_c  = d0_s3;
		diff_c = d0_s3 - d1_s3;
		if (diff_c[DW-1]) begin
			den_c = DW'(-diff_c);
			d0n_c = -d0w_c;
		end else begin
			den_c = DW'(diff_c);
			d0n_c = d0w_c;
		end
		miss_c = (!d0_s3[SW-1] && d0_s3 != '0 && !d1_s3[SW-1] && d1_s3 != '0) ||
			(d0_s3[SW-1] && d1_s3[SW-1]);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sd_s1[i] <= $signed(s_i[i*W +: W]) - $signed(a_i[i*W +: W]);
			ed_s1[i] <= $signed(e_i[i*W +: W]) - $signed(a_i[i*W +: W]);
			es_s1[i] <= $signed(e_i[i*W +: W]) - $signed(s_i[i*W +: W]);
			p0_s2[i] <= $signed(n_s1[i*W +: W]) * sd_s1[i];
			p1_s2[i] <= $signed(n_s1[i*W +: W]) * ed_s1[i];
			es_s2[i] <= es_s1[i];
			es_s3[i] <= es_s2[i];
			es_s4[i] <= es_s3[i];
			m1_s5[i] <= $signed(pts_s4[i*W +: W]) * $signed({1'b0, den_s4});
			m2_s5[i] <= es_s4[i] * d0n_s4;
			num_s6[i] <= m1_s5[i] + m2_s5[i];
			mag_s7[i] <= num_s6[i][NW-1] ? NW'(-num_s6[i]) : NW'(num_s6[i]);
		end
		pts_s1 <= {c_i, b_i, a_i, s_i};
		n_s1   <= n_i;
		pts_s2 <= pts_s1;
		d0_s3  <= p0_s2[0] + p0_s2[1] + p0_s2[2];
		d1_s3  <= p1_s2[0] + p1_s2[1] + p1_s2[2];
		pts_s3 <= pts_s2;
		den_s4 <= den_c;
		d0n_s4 <= d0n_c;
		flg_s4.miss     <= miss_c;
		flg_s4.den_zero <= (diff_c == '0);
		flg_s4.neg      <= 3'b000;
		pts_s4 <= pts_s3;
		den_s5 <= den_s4;
		flg_s5 <= flg_s4;
		pts_s5 <= pts_s4;
		den_s6 <= den_s5;
		flg_s6 <= flg_s5;
		pts_s6 <= pts_s5;
		den_s7 <= den_s6;
		pts_s7 <= pts_s6;
		flg_s7.miss     <= flg_s6.miss;
		flg_s7.den_zero <= flg_s6.den_zero;
		flg_s7.neg      <= {num_s6[2][NW-1], num_s6[1][NW-1], num_s6[0][NW-1]};
	end

	assign out_valid = v_s7;
	assign flags_o   = flg_s7;
	assign den_o     = den_s7;
	assign side_o    = pts_s7;
	assign mag_o     = {mag_s7[2], mag_s7[1], mag_s7[0]};

endmodule

### rtl/ste_div.sv
// ----------------------------------------------------------------------------
// ste_div
// Pipelined restoring divider, one quotient bit per stage, three axes.
// ----------------------------------------------------------------------------
module ste_div #(
	parameter int W  = 16,
	parameter int DW = 2*W+4,
	parameter int NW = 3*W+6
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  ste_pkg::ste_flags_t    flags_i,
	input  logic [2:0][NW-1:0]     mag_i,
	input  logic [DW-1:0]          den_i,
	input  logic [12*W-1:0]        side_i,
	output logic                   out_valid,
	output ste_pkg::ste_flags_t    flags_o,
	output logic [2:0][W-1:0]      quo_o,
	output logic [12*W-1:0]        side_o
);
	import ste_pkg::*;

	logic                vld_sk  [W+1];
	ste_flags_t          flg_sk  [W+1];
	logic [DW-1:0]       den_sk  [W+1];
	logic [12*W-1:0]     side_sk [W+1];
	logic [2:0][NW-1:0]  rem_sk  [W+1];
	logic [2:0][W-1:0]   quo_sk  [W+1];

	assign vld_sk[0]  = in_valid;
	assign flg_sk[0]  = flags_i;
	assign den_sk[0]  = den_i;
	assign side_sk[0] = side_i;
	assign rem_sk[0]  = mag_i;
	assign quo_sk[0]  = '0;

	for (genvar k = 0; k < W; k++) begin : g_stage
		localparam int SH = W-1-k;
		logic [NW-1:0] dsh;

		assign dsh = NW'(den_sk[k]) << SH;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sk[k+1] <= 1'b0;
			end else begin
				vld_sk[k+1] <= vld_sk[k];
			end
		end

		// Subtract the shifted divisor where it fits, shift in the quotient bit
		always_ff @(posedge clk) begin
			for (int ax = 0; ax < 3; ax++) begin
				if (rem_sk[k][ax] >= dsh) begin
					rem_sk[k+1][ax] <= rem_sk[k][ax] - dsh;
					quo_sk[k+1][ax] <= {quo_sk[k][ax][W-2:0], 1'b1};
				end else begin
					rem_sk[k+1][ax] <= rem_sk[k][ax];
					quo_sk[k+1][ax] <= {quo_sk[k][ax][W-2:0], 1'b0};
				end
			end
			flg_sk[k+1]  <= flg_sk[k];
			den_sk[k+1]  <= den_sk[k];
			side_sk[k+1] <= side_sk[k];
		end
	end

	assign out_valid = vld_sk[W];
	assign flags_o   = flg_sk[W];
	assign quo_o     = quo_sk[W];
	assign side_o    = side_sk[W];

endmodule

### rtl/ste_tri.sv
// ----------------------------------------------------------------------------
// ste_tri
// Crossing point assembly and inside-triangle test by edge cross products.
// ----------------------------------------------------------------------------
module ste_tri #(
	parameter int W = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  ste_pkg::ste_flags_t    flags_i,
	input  logic [2:0][W-1:0]      quo_i,
	input  logic [12*W-1:0]        side_i,
	output logic                   out_valid,
	output logic                   plane_hit_o,
	output logic                   tri_hit_o,
	output logic [3*W-1:0]         point_o
);
	import ste_pkg::*;

	localparam int CW = 2*W+3;
	localparam int XW = 4*W+6;
	localparam int TW = 4*W+8;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic ph_s1, ph_s2, ph_s3, ph_s4, ph_s5, ph_s6;
	logic th_s6;
	logic [3*W-1:0] pt_s1, pt_s2, pt_s3, pt_s4, pt_s5, pt_s6;
	logic [9*W-1:0] vtx_s1;

	logic signed [W:0]    tv_s2 [3][3];
	logic signed [W:0]    eg_s2 [3][3];
	logic signed [CW-2:0] pa_s3 [3][3];
	logic signed [CW-2:0] pb_s3 [3][3];
	logic signed [CW-1:0] cr_s4 [3][3];
	logic signed [XW-1:0] x1_s5 [3];
	logic signed [XW-1:0] x2_s5 [3];

	logic signed [TW-1:0] dot1_c, dot2_c;
	logic [3*W-1:0]       pt_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Zero on a miss, segment start when it lies in the plane, else the signed quotient
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			if (flags_i.miss) begin
				pt_c[j*W +: W] = '0;
			end else if (flags_i.den_zero) begin
				pt_c[j*W +: W] = side_i[j*W +: W];
			end else if (flags_i.neg[j]) begin
				pt_c[j*W +: W] = ~quo_i[j] + 1'b1;
			end else begin
				pt_c[j*W +: W] = quo_i[j];
			end
		end
		dot1_c = x1_s5[0] + x1_s5[1] + x1_s5[2];
		dot2_c = x2_s5[0] + x2_s5[1] + x2_s5[2];
	end

	always_ff @(posedge clk) begin
		pt_s1  <= pt_c;
		ph_s1  <= !flags_i.miss;
		vtx_s1 <= side_i[12*W-1:3*W];
		for (int k = 0; k < 3; k++) begin
			for (int j = 0; j < 3; j++) begin
				tv_s2[k][j] <= $signed(pt_s1[j*W +: W]) -
					$signed(vtx_s1[k*3*W + j*W +: W]);
				eg_s2[k][j] <= $signed(vtx_s1[AX_NEXT[k]*3*W + j*W +: W]) -
					$signed(vtx_s1[k*3*W + j*W +: W]);
				pa_s3[k][j] <= tv_s2[k][AX_NEXT[j]] * eg_s2[k][AX_PREV[j]];
				pb_s3[k][j] <= tv_s2[k][AX_PREV[j]] * eg_s2[k][AX_NEXT[j]];
				cr_s4[k][j] <= pa_s3[k][j] - pb_s3[k][j];
			end
		end
		for (int j = 0; j < 3; j++) begin
			x1_s5[j] <= cr_s4[1][j] * cr_s4[0][j];
			x2_s5[j] <= cr_s4[2][j] * cr_s4[0][j];
		end
		pt_s2 <= pt_s1;
		pt_s3 <= pt_s2;
		pt_s4 <= pt_s3;
		pt_s5 <= pt_s4;
		pt_s6 <= pt_s5;
		ph_s2 <= ph_s1;
		ph_s3 <= ph_s2;
		ph_s4 <= ph_s3;
		ph_s5 <= ph_s4;
		ph_s6 <= ph_s5;
		th_s6 <= ph_s5 && !dot1_c[TW-1] && !dot2_c[TW-1];
	end

	assign out_valid   = v_s6;
	assign plane_hit_o = ph_s6;
	assign tri_hit_o   = th_s6;
	assign point_o     = pt_s6;

endmodule

### rtl/segment_triangle_intersection_unit.sv
// Throughput: one request per cycle; busy stays low, the pipeline never stalls.
// The divider spends one stage per quotient bit, which sets most of the latency.
// Reset clears all valid bits at once, dropping any request in flight; no result is repeated.
// The receiver cannot stall: each result shows for the single cycle of done.
// ----------------------------------------------------------------------------
// segment_triangle_intersection_unit
// Segment/plane crossing and inside-triangle test, fully pipelined.
// ----------------------------------------------------------------------------
module segment_triangle_intersection_unit #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [3*COORD_WIDTH-1:0] seg_start,
	input  logic [3*COORD_WIDTH-1:0] seg_end,
	input  logic [3*COORD_WIDTH-1:0] vertex_a,
	input  logic [3*COORD_WIDTH-1:0] vertex_b,
	input  logic [3*COORD_WIDTH-1:0] vertex_c,
	input  logic [3*COORD_WIDTH-1:0] face_normal,
	output logic                     done,
	output logic                     plane_hit,
	output logic                     triangle_hit,
	output logic [3*COORD_WIDTH-1:0] hit_point
);
	import ste_pkg::*;

	localparam int W  = COORD_WIDTH;
	localparam int DW = 2*W+4;
	localparam int NW = 3*W+6;

	logic               pl_valid, dv_valid;
	ste_flags_t         pl_flags, dv_flags;
	logic [2:0][NW-1:0] pl_mag;
	logic [DW-1:0]      pl_den;
	logic [12*W-1:0]    pl_side, dv_side;
	logic [2:0][W-1:0]  dv_quo;

	assign busy = 1'b0;

	ste_plane #(.W(W), .DW(DW), .NW(NW)) u_plane (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.s_i       (seg_start),
		.e_i       (seg_end),
		.a_i       (vertex_a),
		.b_i       (vertex_b),
		.c_i       (vertex_c),
		.n_i       (face_normal),
		.out_valid (pl_valid),
		.flags_o   (pl_flags),
		.mag_o     (pl_mag),
		.den_o     (pl_den),
		.side_o    (pl_side)
	);

	ste_div #(.W(W), .DW(DW), .NW(NW)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pl_valid),
		.flags_i   (pl_flags),
		.mag_i     (pl_mag),
		.den_i     (pl_den),
		.side_i    (pl_side),
		.out_valid (dv_valid),
		.flags_o   (dv_flags),
		.quo_o     (dv_quo),
		.side_o    (dv_side)
	);

	ste_tri #(.W(W)) u_tri (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (dv_valid),
		.flags_i     (dv_flags),
		.quo_i       (dv_quo),
		.side_i      (dv_side),
		.out_valid   (done),
		.plane_hit_o (plane_hit),
		.tri_hit_o   (triangle_hit),
		.point_o     (hit_point)
	);

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised on a stall-free pipeline");

	a_miss_no_tri: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !plane_hit) |-> !triangle_hit)
		else $error("triangle hit reported without a plane hit");

	a_miss_zero_point: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !plane_hit) |-> (hit_point == '0))
		else $error("nonzero hit point on a plane miss");

endmodule
